/* rtl/i2cdw_pkg.sv */
// Shared types and constants for the two-wire DAC write master.
package i2cdw_pkg;

	// Sequencer phase codes; codes above STOP behave as idle.
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_BYTE  = 3'd2;
	localparam logic [2:0] PH_STOP  = 3'd3;

	// Ticks in one byte slot: eight data bits and the acknowledge, two ticks each.
	localparam logic [4:0] BYTE_TICKS = 5'd18;
	localparam logic [4:0] LAST_TICK  = 5'd17;
	localparam logic [3:0] DATA_BITS  = 4'd8;

	localparam logic [1:0] BYTE_ADDR = 2'd0;
	localparam logic [1:0] BYTE_HIGH = 2'd1;
	localparam logic [1:0] BYTE_LOW  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_DIVIDE_MODE    = 1'b0;
	localparam logic CFG_DEVICE_ADDRESS = 1'b1;

	localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h98;

	// Divide by ten: multiply by ceil(2^19 / 10) and keep the top bits.
	localparam logic [15:0] DIV10_RECIP = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

	// One result word as it leaves the sequencer.
	typedef struct packed {
		logic scl;
		logic sda_out;
		logic busy_res;
		logic ack_missing;
		logic done_res;
	} res_t;

	// Configuration seen by the sequencer.
	typedef struct packed {
		logic       divide_mode;
		logic [7:0] device_address;
	} cfg_t;

endpackage

/* rtl/i2cdw_div10.sv */
// Value conditioning: optional divide by ten, then truncation to the 12-bit code.
module i2cdw_div10 (
	input  logic        divide_mode,
	input  logic [15:0] value,
	output logic [11:0] code
);
	import i2cdw_pkg::*;

	logic [31:0] product;
	logic [12:0] quotient;

	assign product  = 32'(value) * 32'(DIV10_RECIP);
	assign quotient = product[DIV10_SHIFT +: 13];
	assign code     = divide_mode ? quotient[11:0] : value[11:0];

endmodule

/* rtl/i2cdw_seq.sv */
// Bus sequencer: phase, bit counter, shift register and the line levels of one tick.
module i2cdw_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 command,
	input  logic [11:0]          code,
	input  logic                 sda_in,
	input  i2cdw_pkg::cfg_t      cfg,
	output i2cdw_pkg::res_t      res
);
	import i2cdw_pkg::*;

	logic [2:0]  phase_q, phase_d;
	logic [4:0]  step_q, step_d;
	logic [1:0]  byte_idx_q, byte_idx_d;
	logic [7:0]  shift_q, shift_d;
	logic [11:0] data_q, data_d;
	logic        ack_q, ack_d;
	logic [4:0]  tick;
	logic [7:0]  next_byte;

	assign tick = (step_q >= BYTE_TICKS) ? LAST_TICK : step_q;

	always_comb begin
		case (byte_idx_q + 2'd1)
			BYTE_HIGH: next_byte = {4'b0000, data_q[11:8]};
			BYTE_LOW:  next_byte = data_q[7:0];
			default:   next_byte = cfg.device_address;
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		step_d     = step_q;
		byte_idx_d = byte_idx_q;
		shift_d    = shift_q;
		data_d     = data_q;
		ack_d      = ack_q;
		res.scl    = 1'b1;
		res.sda_out  = 1'b1;
		res.busy_res = 1'b1;
		res.done_res = 1'b0;
		case (phase_q)
			PH_START: begin
				res.scl     = 1'b0;
				res.sda_out = 1'b0;
				byte_idx_d  = BYTE_ADDR;
				shift_d     = cfg.device_address;
				step_d      = '0;
				phase_d     = PH_BYTE;
			end
			PH_BYTE: begin
				res.scl = tick[0];
				if (tick[4:1] < DATA_BITS) begin
					res.sda_out = shift_q[7];
					if (tick[0]) begin
						shift_d = {shift_q[6:0], 1'b0};
					end
					step_d = tick + 5'd1;
				end else begin
					res.sda_out = 1'b1;
					if (tick[0]) begin
						ack_d  = sda_in;
						step_d = '0;
						if (byte_idx_q >= BYTE_LOW) begin
							byte_idx_d = BYTE_ADDR;
							phase_d    = PH_STOP;
						end else begin
							byte_idx_d = byte_idx_q + 2'd1;
							shift_d    = next_byte;
						end
					end else begin
						step_d = tick + 5'd1;
					end
				end
			end
			PH_STOP: begin
				if (step_q == 5'd0) begin
					res.scl     = 1'b0;
					res.sda_out = 1'b0;
					step_d      = 5'd1;
				end else if (step_q == 5'd1) begin
					res.sda_out = 1'b0;
					step_d      = 5'd2;
				end else begin
					res.done_res = 1'b1;
					step_d       = '0;
					phase_d      = PH_IDLE;
				end
			end
			default: begin
				phase_d      = PH_IDLE;
				res.busy_res = 1'b0;
				if (command) begin
					data_d       = code;
					res.sda_out  = 1'b0;
					res.busy_res = 1'b1;
					step_d       = '0;
					phase_d      = PH_START;
				end
			end
		endcase
		res.ack_missing = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			step_q     <= '0;
			byte_idx_q <= '0;
			shift_q    <= '0;
			data_q     <= '0;
			ack_q      <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			step_q     <= step_d;
			byte_idx_q <= byte_idx_d;
			shift_q    <= shift_d;
			data_q     <= data_d;
			ack_q      <= ack_d;
		end
	end

endmodule

/* rtl/i2c_dac_write_master_unit.sv */
// Top level of the two-wire DAC write master: input register, sequencer, result register.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   command, value, sda_in
//  out      source     out_valid/out_stall scl, sda_out, busy_res, ack_missing, done_res
//  cfg      sink       cfg_we              cfg_index, cfg_data
//
// Every input word is one half-bit tick of the bus and yields exactly one result word.
// An accepted word waits in the input register until the result register can take it;
// with no stall it moves on at the next edge into the result register, which shows it
// until it is taken, and one word per cycle is sustained.
// Reset clears the sequencer to idle and loads the default device address.
// A stalled result holds; the input register keeps taking a word as long as it can
// move into the result register, so stalls ripple back to in_stall in the same cycle.
module i2c_dac_write_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [15:0] value,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl,
	output logic        sda_out,
	output logic        busy_res,
	output logic        ack_missing,
	output logic        done_res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import i2cdw_pkg::*;

	logic        divide_mode_q;
	logic [7:0]  device_address_q;
	cfg_t        cfg;

	logic        valid_s1;
	logic        command_s1;
	logic [15:0] value_s1;
	logic        sda_in_s1;

	logic        valid_s2;
	res_t        res_s2;
	res_t        res;
	logic [11:0] code;
	logic        advance;
	logic        load;

	// Configuration registers; a write takes effect at the edge that carries it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divide_mode_q    <= 1'b0;
			device_address_q <= DEVICE_ADDRESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIVIDE_MODE:    divide_mode_q    <= cfg_data[0];
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	assign cfg.divide_mode    = divide_mode_q;
	assign cfg.device_address = device_address_q;

	// The held word moves on when the result register is empty or being drained.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			command_s1 <= command;
			value_s1   <= value;
			sda_in_s1  <= sda_in;
		end
	end

	i2cdw_div10 u_div10 (
		.divide_mode (divide_mode_q),
		.value       (value_s1),
		.code        (code)
	);

	i2cdw_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.command (command_s1),
		.code    (code),
		.sda_in  (sda_in_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Result register: filled on every processed tick, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign scl         = res_s2.scl;
	assign sda_out     = res_s2.sda_out;
	assign busy_res    = res_s2.busy_res;
	assign ack_missing = res_s2.ack_missing;
	assign done_res    = res_s2.done_res;

endmodule

/* rtl/i2cdw_checker.sv */
// Port-level checks for the two-wire DAC write master, bound to the top level.
module i2cdw_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic scl,
	input logic sda_out,
	input logic busy_res,
	input logic ack_missing,
	input logic done_res
);

	// A held result word keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scl) && $stable(sda_out)
			&& $stable(busy_res) && $stable(ack_missing) && $stable(done_res))
		else $error("result word changed while stalled");

	// Input back-pressure only comes from a blocked result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output side was free");

	// The stop completes with both lines high inside a transfer.
	a_done_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> scl && sda_out && busy_res)
		else $error("stop completion with wrong line levels");

	// When idle the clock line stays high.
	a_idle_scl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> scl && sda_out && !done_res)
		else $error("lines not released while idle");

endmodule

bind i2c_dac_write_master_unit i2cdw_checker u_i2cdw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.scl         (scl),
	.sda_out     (sda_out),
	.busy_res    (busy_res),
	.ack_missing (ack_missing),
	.done_res    (done_res)
);

/* sim/testbench.sv */
// Self-checking testbench for the two-wire DAC write master: directed ticks, then random transfers.
module testbench;
	import i2cdw_pkg::*;

	// A run with no handshake at all for this many cycles means the block has hung.
	localparam int WATCHDOG_LIMIT = 500;
	localparam int DIRECTED_ROWS  = 25;
	// Command tick, start tick, three byte slots and the three stop ticks.
	localparam int TRANSFER_TICKS = 59;
	localparam int TRANSFERS_PER_SETTING = 3;
	localparam int SETTINGS_COUNT = 5;

	// One row of the directed table. Where typed is set, want holds the bus levels
	// that can be read straight off the tick schedule; other rows use the predictor.
	typedef struct packed {
		logic        cmd;
		logic [15:0] val;
		logic        sin;
		logic        typed;
		res_t        want;
	} tick_row_t;

	// The result fields pack as {scl, sda_out, busy_res, ack_missing, done_res}.
	tick_row_t directed [DIRECTED_ROWS] = '{
		{1'b0, 16'h0000, 1'b0, 1'b1, 5'b11000},  // idle after reset: lines released
		{1'b0, 16'hffff, 1'b1, 1'b1, 5'b11000},  // a value without a command is ignored
		{1'b1, 16'hffff, 1'b0, 1'b1, 5'b10100},  // start condition: data falls, clock high
		{1'b1, 16'h0000, 1'b1, 1'b1, 5'b00100},  // start tick; the command while busy is ignored
		{1'b0, 16'h1234, 1'b0, 1'b0, 5'b00000},
		{1'b1, 16'h0001, 1'b1, 1'b0, 5'b00000},
		{1'b0, 16'h8000, 1'b0, 1'b0, 5'b00000},
		{1'b0, 16'h7fff, 1'b1, 1'b0, 5'b00000},
		{1'b1, 16'haaaa, 1'b0, 1'b0, 5'b00000},
		{1'b0, 16'h5555, 1'b1, 1'b0, 5'b00000},
		{1'b0, 16'h0fff, 1'b0, 1'b0, 5'b00000},
		{1'b1, 16'hf000, 1'b1, 1'b0, 5'b00000},
		{1'b0, 16'h00ff, 1'b0, 1'b0, 5'b00000},
		{1'b0, 16'hff00, 1'b1, 1'b0, 5'b00000},
		{1'b1, 16'h0f0f, 1'b0, 1'b0, 5'b00000},
		{1'b0, 16'hf0f0, 1'b1, 1'b0, 5'b00000},
		{1'b0, 16'h3333, 1'b0, 1'b0, 5'b00000},
		{1'b1, 16'hcccc, 1'b1, 1'b0, 5'b00000},
		{1'b0, 16'h9999, 1'b0, 1'b0, 5'b00000},
		{1'b0, 16'h6666, 1'b1, 1'b0, 5'b00000},
		{1'b0, 16'h0000, 1'b0, 1'b0, 5'b00000},  // acknowledge low tick of the address byte
		{1'b1, 16'hffff, 1'b1, 1'b0, 5'b00000},  // acknowledge high tick: no acknowledge
		{1'b0, 16'h4321, 1'b0, 1'b0, 5'b00000},
		{1'b0, 16'h8765, 1'b1, 1'b0, 5'b00000},
		{1'b1, 16'hfedc, 1'b0, 1'b0, 5'b00000}
	};

	// Raw values at the edges of the 12-bit code, with and without the divide by ten.
	localparam logic [15:0] EDGE_VALUES [6] = '{
		16'h0000, 16'hffff, 16'h0fff, 16'h1000, 16'd9, 16'd40959
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [15:0] value;
	logic        sda_in;
	logic        out_valid;
	logic        out_stall;
	logic        scl;
	logic        sda_out;
	logic        busy_res;
	logic        ack_missing;
	logic        done_res;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	// Side information that travels with the word on the input channel, so that the
	// checker can tell a typed-in expectation from a predicted one.
	logic row_typed;
	res_t row_want;

	// While quiet is set neither side idles.
	logic quiet;

	// Predictor copy of the configuration and of the sequencer state.
	logic        pred_divide;
	logic [7:0]  pred_address;
	logic [2:0]  pred_phase;
	logic [4:0]  pred_steps;
	logic [1:0]  pred_byte;
	logic [7:0]  pred_shift;
	logic [11:0] pred_code;
	logic        pred_nack;

	// Bus levels still owed by the block, oldest first.
	res_t bus_levels_due [$];

	int errors;
	int words_sent;
	int words_checked;
	int transfers_seen;
	int nacks_seen;
	int quiet_cycles;

	i2c_dac_write_master_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.value       (value),
		.sda_in      (sda_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.scl         (scl),
		.sda_out     (sda_out),
		.busy_res    (busy_res),
		.ack_missing (ack_missing),
		.done_res    (done_res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advances the predictor by one half-bit tick and returns the levels it drives.
	function automatic res_t dac_tick(input logic cmd, input logic [15:0] val, input logic sin);
		res_t        r;
		logic [4:0]  s;
		logic [15:0] v;
		r = '{scl: 1'b1, sda_out: 1'b1, busy_res: 1'b1, ack_missing: 1'b0, done_res: 1'b0};
		case (pred_phase)
			PH_START: begin
				// Clock goes low with data still low; the address byte is loaded here,
				// so a register write during the transfer only matters up to this tick.
				r.scl = 1'b0;
				r.sda_out = 1'b0;
				pred_byte = BYTE_ADDR;
				pred_shift = pred_address;
				pred_steps = '0;
				pred_phase = PH_BYTE;
			end
			PH_BYTE: begin
				s = pred_steps;
				// A step count past the last tick is taken as the acknowledge high tick.
				if (s >= BYTE_TICKS) begin
					s = LAST_TICK;
				end
				r.scl = s[0];
				if (s[4:1] < DATA_BITS) begin
					r.sda_out = pred_shift[7];
					if (r.scl) begin
						pred_shift = {pred_shift[6:0], 1'b0};
					end
					pred_steps = s + 5'd1;
				end else begin
					// Data line released for the acknowledge pulse.
					r.sda_out = 1'b1;
					if (r.scl) begin
						pred_nack = sin;
						pred_steps = '0;
						if (pred_byte >= BYTE_LOW) begin
							pred_byte = BYTE_ADDR;
							pred_phase = PH_STOP;
						end else begin
							pred_byte = pred_byte + 2'd1;
							pred_shift = (pred_byte == BYTE_HIGH) ?
								{4'h0, pred_code[11:8]} : pred_code[7:0];
						end
					end else begin
						pred_steps = s + 5'd1;
					end
				end
			end
			PH_STOP: begin
				// Data is pulled low before the clock rises, then released.
				if (pred_steps == 5'd0) begin
					r.scl = 1'b0;
					r.sda_out = 1'b0;
					pred_steps = 5'd1;
				end else if (pred_steps == 5'd1) begin
					r.sda_out = 1'b0;
					pred_steps = 5'd2;
				end else begin
					r.done_res = 1'b1;
					pred_steps = '0;
					pred_phase = PH_IDLE;
				end
			end
			default: begin
				// Idle, and any unused phase code, which behaves as idle.
				pred_phase = PH_IDLE;
				r.busy_res = 1'b0;
				if (cmd) begin
					v = pred_divide ? (val / 16'd10) : val;
					pred_code = v[11:0];
					r.sda_out = 1'b0;
					r.busy_res = 1'b1;
					pred_steps = '0;
					pred_phase = PH_START;
				end
			end
		endcase
		r.ack_missing = pred_nack;
		return r;
	endfunction

	task automatic check_level(input string what, input logic want, input logic got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, what, want, got);
		end
	endtask

	// Checks each result word against the oldest expectation, then records the
	// expectation for the input word accepted at the same edge. A result always
	// trails its input word through the input and result registers, so the order
	// inside this block is safe.
	always @(posedge clk) begin
		res_t want;
		res_t predicted;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (bus_levels_due.size() == 0) begin
					errors++;
					$display("%0t: result word with nothing expected, actual %b", $time,
						{scl, sda_out, busy_res, ack_missing, done_res});
				end else begin
					want = bus_levels_due.pop_front();
					check_level("scl", want.scl, scl);
					check_level("sda_out", want.sda_out, sda_out);
					check_level("busy_res", want.busy_res, busy_res);
					check_level("ack_missing", want.ack_missing, ack_missing);
					check_level("done_res", want.done_res, done_res);
					words_checked++;
					if (done_res === 1'b1) begin
						transfers_seen++;
						if (ack_missing === 1'b1) begin
							nacks_seen++;
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				// The predictor always runs so that its state follows the block; a
				// typed-in row replaces only the expectation that is stored.
				predicted = dac_tick(command, value, sda_in);
				bus_levels_due.push_back(row_typed ? row_want : predicted);
			end
		end
	end

	// The receiver stalls at random, with a chance of 11 in a hundred at each edge, except while quiet is set.
	always @(posedge clk) begin
		out_stall <= arst_n && !quiet && ($urandom_range(0, 99) < 11);
	end

	// Counts cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("i2c_dac_write_master_unit regression: fail");
			$finish;
		end
	end

	// Presents one word and returns at the edge that accepts it. The sender idles
	// before the word at random; valid is only ever assigned once per time step.
	task automatic put_word(input logic cmd, input logic [15:0] val, input logic sin,
			input logic typed, input res_t want);
		while (!quiet && ($urandom_range(0, 99) < 11)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		value <= val;
		sda_in <= sin;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		words_sent++;
	endtask

	// Plain ticks; with noise set, about one in five carries a start command that the
	// busy block must ignore. About three in ten ticks report a missing acknowledge.
	task automatic run_ticks(input int count, input logic noise);
		for (int i = 0; i < count; i++) begin
			put_word(noise && ($urandom_range(0, 99) < 20), 16'($urandom_range(0, 65535)),
				$urandom_range(0, 99) < 30, 1'b0, '0);
		end
	endtask

	// One complete write: the start command, the rest of the transfer, and a short
	// idle stretch in which stray values and data levels must change nothing.
	task automatic send_transfer(input logic [15:0] val);
		put_word(1'b1, val, 1'($urandom_range(0, 1)), 1'b0, '0);
		run_ticks(TRANSFER_TICKS - 1, 1'b1);
		run_ticks($urandom_range(1, 4), 1'b0);
	endtask

	// Waits until the block has returned every result, then lets its pipeline settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bus_levels_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	// Writes both registers on back-to-back edges, keeping the write enable high
	// between them. The upper data bits of the one-bit register carry junk.
	task automatic write_settings(input logic divide, input logic [7:0] address);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DIVIDE_MODE;
		cfg_data <= {7'($urandom_range(0, 127)), divide};
		@(posedge clk);
		pred_divide = divide;
		cfg_index <= CFG_DEVICE_ADDRESS;
		cfg_data <= address;
		@(posedge clk);
		pred_address = address;
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] val;
		logic        divide;
		logic [7:0]  address;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = 1'b0;
		value = '0;
		sda_in = 1'b0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DIVIDE_MODE;
		cfg_data = '0;
		row_typed = 1'b0;
		row_want = '0;
		quiet = 1'b0;
		quiet_cycles = 0;
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		transfers_seen = 0;
		nacks_seen = 0;
		pred_divide = 1'b0;
		pred_address = DEVICE_ADDRESS_RST;
		pred_phase = PH_IDLE;
		pred_steps = '0;
		pred_byte = BYTE_ADDR;
		pred_shift = '0;
		pred_code = '0;
		pred_nack = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run on the reset settings. It stops partway into the high
		// nibble byte; the ticks after it finish that transfer.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			put_word(directed[i].cmd, directed[i].val, directed[i].sin,
				directed[i].typed, directed[i].want);
		end
		run_ticks(TRANSFER_TICKS - (DIRECTED_ROWS - 2) + 4, 1'b0);
		drain_results();

		// Random part: several register settings, the extremes among them, with a few
		// transfers each. The first transfer of a setting uses an edge value.
		for (int setting = 0; setting < SETTINGS_COUNT; setting++) begin
			case (setting)
				0: begin
					divide = 1'b1;
					address = 8'h00;
				end
				1: begin
					divide = 1'b0;
					address = 8'hff;
				end
				2: begin
					divide = 1'b1;
					address = 8'($urandom_range(0, 255));
				end
				3: begin
					divide = 1'b0;
					address = DEVICE_ADDRESS_RST;
				end
				default: begin
					divide = 1'($urandom_range(0, 1));
					address = 8'($urandom_range(0, 255));
				end
			endcase
			write_settings(divide, address);
			// One setting runs with both sides at full rate.
			quiet = (setting == 1);
			for (int k = 0; k < TRANSFERS_PER_SETTING; k++) begin
				if (k == 0) begin
					val = EDGE_VALUES[$urandom_range(0, 5)];
				end else begin
					case ($urandom_range(0, 3))
						0: val = 16'($urandom_range(0, 4095));
						1: val = 16'($urandom_range(40900, 40969));
						default: val = 16'($urandom_range(0, 65535));
					endcase
				end
				send_transfer(val);
			end
			drain_results();
		end
		quiet = 1'b0;

		// Every word has been accepted; wait for the last results and a little more.
		drain_results();
		repeat (4) @(posedge clk);
		if (bus_levels_due.size() != 0) begin
			errors++;
			$display("%0t: %0d expected result words never arrived", $time,
				bus_levels_due.size());
		end

		$display("Sent %0d words and checked %0d results over %0d register settings.",
			words_sent, words_checked, SETTINGS_COUNT + 1);
		$display("Saw %0d completed transfers, %0d of them ending without acknowledge.",
			transfers_seen, nacks_seen);
		if (errors == 0) begin
			$display("i2c_dac_write_master_unit regression: pass");
		end else begin
			$display("i2c_dac_write_master_unit regression: fail");
		end
		$finish;
	end

endmodule
